// ===== rtl/arp_pkg.sv =====
// Shared types, codes and helpers of the AT response line parser.
package arp_pkg;

	// Function codes of an input word.
	localparam logic [1:0] FUNC_BYTE  = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PREFIX_WANTED = 2'd0;
	localparam logic [1:0] CFG_PREFIX_LENGTH = 2'd1;
	localparam logic [1:0] CFG_PREFIX_LOW    = 2'd2;
	localparam logic [1:0] CFG_PREFIX_HIGH   = 2'd3;

	// Status bit positions.
	localparam int ST_OK     = 0;
	localparam int ST_ERROR  = 1;
	localparam int ST_READY  = 2;
	localparam int ST_USER   = 3;
	localparam int ST_PROMPT = 4;
	localparam int ST_LINE   = 5;

	// Characters of interest.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_PROMPT = 8'h3E;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	// Folded (lower case) letters of the OK and ERROR words.
	localparam logic [7:0] CH_LOWER_O = 8'h6F;
	localparam logic [7:0] CH_LOWER_K = 8'h6B;
	localparam logic [7:0] CH_LOWER_E = 8'h65;
	localparam logic [7:0] CH_LOWER_R = 8'h72;

	// Input word.
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
		logic [5:0] clear_mask;
		logic       rearm;
		logic [6:0] read_index;
	} arp_in_t;

	// Result word.
	typedef struct packed {
		logic [5:0] status;
		logic [6:0] response_length;
		logic [7:0] read_data;
	} arp_out_t;

	// Configuration as seen by the match logic.
	typedef struct packed {
		logic         prefix_wanted;
		logic [4:0]   prefix_length;
		logic [127:0] prefix_chars;
	} arp_cfg_t;

	// Outcome of the comparisons on a finished line.
	typedef struct packed {
		logic is_ok;
		logic is_error;
		logic prefix_hit;
	} arp_match_t;

	// ASCII upper case letters become lower case, everything else passes.
	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			return c + 8'd32;
		end
		return c;
	endfunction

endpackage

// ===== rtl/arp_in_if.sv =====
// Input channel of the AT response line parser.
interface arp_in_if;
	import arp_pkg::*;

	logic    valid;
	logic    ready;
	arp_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/arp_out_if.sv =====
// Result channel of the AT response line parser.
interface arp_out_if;
	import arp_pkg::*;

	logic     valid;
	logic     ready;
	arp_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/arp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module arp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read; the read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/arp_cfg_regs.sv =====
// Configuration registers of the AT response line parser.
module arp_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output arp_pkg::arp_cfg_t  cfg
);
	import arp_pkg::*;

	logic         wanted_q;
	logic [4:0]   length_q;
	logic [63:0]  chars_low_q;
	logic [63:0]  chars_high_q;

	// Register writes decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q     <= 1'b0;
			length_q     <= '0;
			chars_low_q  <= '0;
			chars_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PREFIX_WANTED: wanted_q     <= cfg_data[0];
				CFG_PREFIX_LENGTH: length_q     <= cfg_data[4:0];
				CFG_PREFIX_LOW:    chars_low_q  <= cfg_data;
				CFG_PREFIX_HIGH:   chars_high_q <= cfg_data;
			endcase
		end
	end

	assign cfg.prefix_wanted = wanted_q;
	assign cfg.prefix_length = length_q;
	assign cfg.prefix_chars  = {chars_high_q, chars_low_q};

endmodule

// ===== rtl/arp_line_match.sv =====
// Compares the head of a finished line with OK, ERROR and the prefix.
module arp_line_match #(
	parameter int PREFIX_MAX = 16,
	parameter int SHADOW     = 16,
	parameter int LW         = 7
) (
	input  logic [7:0]          head [SHADOW],
	input  logic [LW-1:0]       line_len,
	input  arp_pkg::arp_cfg_t   cfg,
	output arp_pkg::arp_match_t result
);
	import arp_pkg::*;

	logic [5:0] eff_len;
	logic       prefix_hit;

	// Prefix length saturates at the prefix capacity.
	assign eff_len = (6'(cfg.prefix_length) > 6'(PREFIX_MAX)) ? 6'(PREFIX_MAX)
		: 6'(cfg.prefix_length);

	// Head bytes are stored folded, so only the prefix side is folded here.
	always_comb begin
		logic       live;
		logic       miss;
		logic [7:0] pch;
		live = 1'b1;
		miss = 1'b0;
		for (int i = 0; i < PREFIX_MAX; i++) begin
			pch = cfg.prefix_chars[8*i +: 8];
			if (pch == CH_NUL) begin
				live = 1'b0;
			end
			if (live && (i < int'(eff_len))) begin
				if ((i >= int'(line_len)) || (head[i] != fold(pch))) begin
					miss = 1'b1;
				end
			end
		end
		prefix_hit = !miss;
	end

	assign result.prefix_hit = prefix_hit;
	assign result.is_ok = (line_len == LW'(2)) && (head[0] == CH_LOWER_O)
		&& (head[1] == CH_LOWER_K);
	assign result.is_error = (line_len == LW'(5)) && (head[0] == CH_LOWER_E)
		&& (head[1] == CH_LOWER_R) && (head[2] == CH_LOWER_R)
		&& (head[3] == CH_LOWER_O) && (head[4] == CH_LOWER_R);

endmodule

// ===== rtl/at_response_line_parser.sv =====
// Top level of the AT response line parser: line assembly, capture and read-out.
//
//   channel | direction | handshake        | word
//   req     | in        | valid and ready  | func, rx_byte, clear_mask, rearm, read_index
//   rsp     | out       | valid and ready  | status, response_length, read_data
//   cfg     | in        | cfg_we only      | cfg_index, cfg_data
//
// One word is accepted per cycle; its result appears in the output register
// in the following cycle. The line memory is written and read in the accept cycle,
// and its registered read data lands together with the result word.
// A stalled result blocks the next word only while it is not taken.
// Reset clears the control state at once; the line memory needs no clearing.
module at_response_line_parser #(
	parameter int LINE_BYTES = 128,
	parameter int PREFIX_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	arp_in_if.sink      req,
	arp_out_if.source   rsp
);
	import arp_pkg::*;

	localparam int LW     = $clog2(LINE_BYTES);
	localparam int SHADOW = (PREFIX_MAX > 5) ? PREFIX_MAX : 5;
	localparam int SW     = $clog2(SHADOW);
	localparam int HW     = (LW > 7) ? LW : 7;

	arp_cfg_t   cfg;
	arp_match_t match;

	logic          bank_q, bank_d;
	logic [LW-1:0] line_len_q, line_len_d;
	logic [LW-1:0] held_q, held_d;
	logic [5:0]    status_q, status_d;
	logic          armed_q, armed_d;
	logic [7:0]    head_q [SHADOW];

	logic          acc;
	logic          term;
	logic [7:0]    wbyte;
	logic [LW-1:0] pos;
	logic [LW-1:0] len_inc;
	logic          mem_we, mem_re, head_we, rd_hit;
	logic [HW-1:0] held_ext;
	logic [7:0]    mem_q;

	logic       valid_s1;
	logic [5:0] status_s1;
	logic [6:0] resp_len_s1;
	logic       rd_hit_s1;

	arp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	arp_line_match #(
		.PREFIX_MAX (PREFIX_MAX),
		.SHADOW     (SHADOW),
		.LW         (LW)
	) u_match (
		.head     (head_q),
		.line_len (pos),
		.cfg      (cfg),
		.result   (match)
	);

	arp_ram #(
		.WIDTH (8),
		.DEPTH (2 * (2 ** LW))
	) u_lines (
		.clk   (clk),
		.we    (acc && mem_we),
		.waddr ({bank_q, pos}),
		.wdata (wbyte),
		.re    (mem_re),
		.raddr ({~bank_q, LW'(req.data.read_index)}),
		.rdata (mem_q)
	);

	// The next word is taken whenever the output register is free or draining.
	assign req.ready = !valid_s1 || rsp.ready;
	assign acc       = req.valid && req.ready;

	assign pos   = line_len_q;
	assign term  = (req.data.rx_byte == CH_NUL) || (req.data.rx_byte == CH_LF)
		|| (req.data.rx_byte == CH_CR);
	assign wbyte = term ? CH_NUL : req.data.rx_byte;
	assign len_inc = (int'(pos) < LINE_BYTES - 1) ? pos + LW'(1) : pos;

	// Next state for the word at the input.
	always_comb begin
		bank_d     = bank_q;
		line_len_d = line_len_q;
		held_d     = held_q;
		status_d   = status_q;
		armed_d    = armed_q;
		mem_we     = 1'b0;
		head_we    = 1'b0;
		rd_hit     = 1'b0;
		unique case (req.data.func)
			FUNC_BYTE: begin
				mem_we  = 1'b1;
				head_we = int'(pos) < SHADOW;
				if (!term) begin
					line_len_d = len_inc;
					if (req.data.rx_byte == CH_PROMPT) begin
						status_d[ST_PROMPT] = 1'b1;
					end
				end else begin
					line_len_d = '0;
					if (pos != '0) begin
						status_d[ST_LINE] = 1'b1;
						if (match.is_ok) begin
							status_d[ST_OK]    = 1'b1;
							status_d[ST_READY] = 1'b1;
						end else if (match.is_error) begin
							status_d[ST_ERROR] = 1'b1;
						end else if (held_q == '0) begin
							if (!cfg.prefix_wanted) begin
								held_d = len_inc;
								bank_d = ~bank_q;
							end else if (armed_q && match.prefix_hit) begin
								held_d            = len_inc;
								bank_d            = ~bank_q;
								armed_d           = 1'b0;
								status_d[ST_USER] = 1'b1;
							end
						end
					end
				end
			end
			FUNC_CLEAR: begin
				status_d = status_q & ~req.data.clear_mask;
				if (req.data.rearm) begin
					held_d  = '0;
					armed_d = 1'b1;
				end
			end
			FUNC_READ: begin
				rd_hit = (int'(req.data.read_index) < int'(held_q))
					&& (int'(req.data.read_index) < LINE_BYTES);
			end
			default: begin
			end
		endcase
	end

	assign mem_re   = acc && rd_hit;
	assign held_ext = HW'(held_d);

	// Control state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q     <= 1'b0;
			line_len_q <= '0;
			held_q     <= '0;
			status_q   <= '0;
			armed_q    <= 1'b0;
			valid_s1   <= 1'b0;
		end else begin
			if (acc) begin
				bank_q     <= bank_d;
				line_len_q <= line_len_d;
				held_q     <= held_d;
				status_q   <= status_d;
				armed_q    <= armed_d;
			end
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
		end
	end

	// Folded copy of the line head and the result word payload.
	always_ff @(posedge clk) begin
		if (acc && mem_we && head_we) begin
			head_q[SW'(pos)] <= fold(wbyte);
		end
		if (acc) begin
			status_s1   <= status_d;
			resp_len_s1 <= (held_ext > HW'(127)) ? 7'd127 : 7'(held_ext);
			rd_hit_s1   <= rd_hit;
		end
	end

	assign rsp.valid                = valid_s1;
	assign rsp.data.status          = status_s1;
	assign rsp.data.response_length = resp_len_s1;
	assign rsp.data.read_data       = rd_hit_s1 ? mem_q : 8'd0;

endmodule

// ===== rtl/arp_checker.sv =====
// Port-level checks of the AT response line parser and their binding.
module arp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [20:0] rsp_data
);

	// A held result keeps its word.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result word changed while stalled");

	// An accepted word always yields a result in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted word produced no result");

	// A word is never taken while a stalled result still occupies the output.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> !rsp_valid || rsp_ready)
		else $error("input accepted over a stalled result");

	// Read data comes only from a held response.
	a_read_needs_response: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data[7:0] != 8'd0) |-> (rsp_data[14:8] != 7'd0))
		else $error("read data without a held response");

endmodule

bind at_response_line_parser arp_checker u_arp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ===== sim/arp_response_checker.sv =====
// Checker of the AT response line parser: predicts every result word and compares it.
module arp_response_checker #(
	parameter int LINE_BYTES = 128,
	parameter int PREFIX_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	arp_in_if           req,
	arp_out_if          rsp,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import arp_pkg::*;

	// Shadow copy of the parser state.
	logic [7:0]   line_mem [0:2*LINE_BYTES-1];
	logic         bank;
	int unsigned  line_len;
	int unsigned  held_len;
	logic [5:0]   flags;
	logic         armed;

	// Shadow copy of the configuration registers.
	logic         want_prefix;
	logic [4:0]   prefix_len;
	logic [127:0] prefix_text;

	arp_out_t     due_responses [$];
	int           fault_count = 0;

	assign mismatches = fault_count;

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch in %s: got %0h, expected %0h", what, got, want);
		fault_count++;
	endtask

	function automatic logic [7:0] lower_case(logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] line_at(int unsigned i);
		return line_mem[int'(bank) * LINE_BYTES + (i % LINE_BYTES)];
	endfunction

	// Exact, case-blind comparison of the finished line with a lower case word.
	function automatic logic line_is(int unsigned len, string word);
		if (len != word.len()) begin
			return 1'b0;
		end
		for (int i = 0; i < word.len(); i++) begin
			if (lower_case(line_at(i)) != word[i]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// The prefix is cut at PREFIX_MAX characters or at its first zero character.
	function automatic logic prefix_hit(int unsigned len);
		int unsigned n;
		logic [7:0]  p;
		n = (prefix_len > PREFIX_MAX) ? PREFIX_MAX : prefix_len;
		for (int unsigned i = 0; i < n; i++) begin
			p = prefix_text[i*8 +: 8];
			if (p == CH_NUL) begin
				break;
			end
			if (i >= len) begin
				return 1'b0;
			end
			if (lower_case(line_at(i)) != lower_case(p)) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// One received byte: store it, and on a terminator classify the line.
	function automatic void take_byte(logic [7:0] c);
		logic        ends;
		logic        take;
		int unsigned pos;
		ends = (c == CH_NUL) || (c == CH_LF) || (c == CH_CR);
		pos = line_len;
		line_mem[int'(bank) * LINE_BYTES + (pos % LINE_BYTES)] = ends ? CH_NUL : c;
		// Past the end of the buffer the last slot is overwritten.
		if (line_len < LINE_BYTES - 1) begin
			line_len++;
		end
		if (!ends) begin
			if (c == CH_PROMPT) begin
				flags[ST_PROMPT] = 1'b1;
			end
		end else begin
			if (line_len > 1) begin
				flags[ST_LINE] = 1'b1;
				if (line_is(pos, "ok")) begin
					flags[ST_OK] = 1'b1;
					flags[ST_READY] = 1'b1;
				end else if (line_is(pos, "error")) begin
					flags[ST_ERROR] = 1'b1;
				end else if (held_len == 0) begin
					take = 1'b0;
					if (!want_prefix) begin
						take = 1'b1;
					end else if (armed && prefix_hit(pos)) begin
						take = 1'b1;
						armed = 1'b0;
						flags[ST_USER] = 1'b1;
					end
					// A captured line stays in its bank; new bytes go to the other one.
					if (take) begin
						held_len = line_len;
						bank = !bank;
					end
				end
			end
			line_len = 0;
		end
	endfunction

	// Advances the shadow state by one input word and returns the result word.
	function automatic arp_out_t parse_word(arp_in_t w);
		arp_out_t r;
		r = '0;
		case (w.func)
			FUNC_BYTE: begin
				take_byte(w.rx_byte);
			end
			FUNC_CLEAR: begin
				flags &= ~w.clear_mask;
				if (w.rearm) begin
					held_len = 0;
					armed = 1'b1;
				end
			end
			FUNC_READ: begin
				if (w.read_index < held_len && w.read_index < LINE_BYTES) begin
					r.read_data = line_mem[int'(!bank) * LINE_BYTES + w.read_index];
				end
			end
			default: begin
			end
		endcase
		r.status = flags;
		r.response_length = (held_len > 127) ? 7'd127 : 7'(held_len);
		return r;
	endfunction

	// Watch the channels: configuration first, then the result, then the new word.
	always @(posedge clk) begin
		arp_out_t want;
		if (!arst_n) begin
			foreach (line_mem[i]) begin
				line_mem[i] = '0;
			end
			bank = 1'b0;
			line_len = 0;
			held_len = 0;
			flags = '0;
			armed = 1'b0;
			want_prefix = 1'b0;
			prefix_len = '0;
			prefix_text = '0;
			due_responses.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PREFIX_WANTED: want_prefix = cfg_data[0];
					CFG_PREFIX_LENGTH: prefix_len = cfg_data[4:0];
					CFG_PREFIX_LOW:    prefix_text[63:0] = cfg_data;
					CFG_PREFIX_HIGH:   prefix_text[127:64] = cfg_data;
					default: begin
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (due_responses.size() == 0) begin
					flag_mismatch("result with nothing due", int'(rsp.data), 0);
				end else begin
					want = due_responses.pop_front();
					if (rsp.data.status !== want.status) begin
						flag_mismatch("status", rsp.data.status, want.status);
					end
					if (rsp.data.response_length !== want.response_length) begin
						flag_mismatch("response_length", rsp.data.response_length,
							want.response_length);
					end
					if (rsp.data.read_data !== want.read_data) begin
						flag_mismatch("read_data", rsp.data.read_data, want.read_data);
					end
				end
			end
			if (req.valid && req.ready) begin
				due_responses.push_back(parse_word(req.data));
			end
		end
		outstanding <= due_responses.size();
	end

endmodule

// ===== sim/tb_at_response_line_parser.sv =====
// Testbench top of the AT response line parser: stimulus, flow control and verdict.
module tb_at_response_line_parser;
	timeunit 1ns;
	timeprecision 1ps;
	import arp_pkg::*;

	localparam int         CLK_PERIOD     = 12;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         HOLD_CYCLES    = 150;
	localparam int         PHASES         = 8;
	localparam int         PHASE_WORDS    = 150;
	localparam logic [1:0] FUNC_UNUSED    = 2'd3;
	localparam string      PREFIX_ALPHABET = "AT+cmgs:7E";

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	arp_in_if  req ();
	arp_out_if rsp ();

	int mismatches;
	int outstanding;

	// Stimulus bookkeeping.
	int           words_sent = 0;
	int           fast_words = 0;
	logic         tx_burst = 1'b0;
	int           holds_wanted = 0;
	int           holds_done = 0;
	logic [127:0] prefix_text = '0;
	int           prefix_eff = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	at_response_line_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

	arp_response_checker resp_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Offers one word after a random gap and waits until it is taken.
	task automatic send_word(arp_in_t w);
		int gap;
		gap = (fast_words > 0 || tx_burst) ? 0 : $urandom_range(0, 11);
		if (fast_words > 0) begin
			fast_words--;
		end
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= w;
		do @(posedge clk); while (!(req.valid && req.ready));
		words_sent++;
	endtask

	// Unused fields of every word built here carry random values.
	function automatic arp_in_t noise_word();
		return arp_in_t'(24'($urandom));
	endfunction

	task automatic send_char(logic [7:0] c);
		arp_in_t w;
		w = noise_word();
		w.func = FUNC_BYTE;
		w.rx_byte = c;
		send_word(w);
	endtask

	task automatic send_clear(logic [5:0] mask, logic rearm);
		arp_in_t w;
		w = noise_word();
		w.func = FUNC_CLEAR;
		w.clear_mask = mask;
		w.rearm = rearm;
		send_word(w);
	endtask

	task automatic send_read(logic [6:0] index);
		arp_in_t w;
		w = noise_word();
		w.func = FUNC_READ;
		w.read_index = index;
		send_word(w);
	endtask

	task automatic send_text(string s, logic [7:0] term);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
		send_char(term);
	endtask

	function automatic logic [7:0] random_case(logic [7:0] c);
		logic [7:0] up;
		up = c & 8'hDF;
		if (up >= CH_UPPER_A && up <= CH_UPPER_Z && $urandom_range(0, 1) == 1) begin
			return c ^ 8'h20;
		end
		return c;
	endfunction

	function automatic logic [7:0] random_end();
		case ($urandom_range(0, 2))
			0: return CH_CR;
			1: return CH_LF;
			default: return CH_NUL;
		endcase
	endfunction

	function automatic logic [7:0] alphabet_char();
		return PREFIX_ALPHABET[$urandom_range(0, PREFIX_ALPHABET.len() - 1)];
	endfunction

	// Mostly printable text; now and then any byte, which may break the line early.
	function automatic logic [7:0] body_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return CH_PROMPT;
		end else if (r < 15) begin
			return 8'($urandom);
		end else if (r < 35) begin
			return alphabet_char();
		end
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	function automatic logic [127:0] alphabet_prefix();
		logic [127:0] t;
		for (int i = 0; i < 16; i++) begin
			t[i*8 +: 8] = alphabet_char();
		end
		return t;
	endfunction

	// Drops valid and waits until every result has been taken.
	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes all four registers on consecutive edges while the block is idle.
	task automatic configure(logic wanted, logic [4:0] len, logic [127:0] text);
		int n;
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PREFIX_WANTED;
		cfg_data <= {63'd0, wanted};
		@(posedge clk);
		cfg_index <= CFG_PREFIX_LENGTH;
		cfg_data <= {59'd0, len};
		@(posedge clk);
		cfg_index <= CFG_PREFIX_LOW;
		cfg_data <= text[63:0];
		@(posedge clk);
		cfg_index <= CFG_PREFIX_HIGH;
		cfg_data <= text[127:64];
		@(posedge clk);
		cfg_we <= 1'b0;
		// Keep the usable part of the prefix for building matching lines.
		prefix_text = text;
		n = (len > 16) ? 16 : len;
		prefix_eff = 0;
		for (int i = 0; i < n; i++) begin
			if (text[i*8 +: 8] == CH_NUL) begin
				break;
			end
			prefix_eff++;
		end
	endtask

	// One line: OK, ERROR, prefixed text, a buffer overflow, an empty or a plain line.
	task automatic send_line();
		logic [7:0] chars [$];
		string      err_word;
		int         kind;
		int         k;
		int         n;
		kind = $urandom_range(0, 99);
		n = 0;
		err_word = "ERROR";
		if (kind < 10) begin
			chars.push_back(random_case("O"));
			chars.push_back(random_case("K"));
		end else if (kind < 18) begin
			for (int i = 0; i < err_word.len(); i++) begin
				chars.push_back(random_case(err_word[i]));
			end
		end else if (kind < 50) begin
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, prefix_eff) : prefix_eff;
			for (int i = 0; i < k; i++) begin
				chars.push_back(random_case(prefix_text[i*8 +: 8]));
			end
			n = $urandom_range(0, 6);
		end else if (kind < 51) begin
			k = $urandom_range(120, 140);
			for (int i = 0; i < k; i++) begin
				chars.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end
		end else if (kind >= 58) begin
			n = $urandom_range(1, 10);
		end
		for (int i = 0; i < n; i++) begin
			chars.push_back(body_char());
		end
		tx_burst = ($urandom_range(0, 4) == 0);
		foreach (chars[i]) begin
			send_char(chars[i]);
		end
		send_char(random_end());
	endtask

	// Reads, clears and unused words between lines.
	task automatic send_extras();
		arp_in_t w;
		int      r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			send_read(($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 12))
				: 7'($urandom_range(0, 127)));
		end else if (r < 45) begin
			send_clear(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
		end else if (r < 48) begin
			w = noise_word();
			w.func = FUNC_UNUSED;
			send_word(w);
		end
	endtask

	// Result side: random stalls, bursts without stalls, and long hold-offs on request.
	initial begin : result_sink
		int   wait_cycles;
		int   taken;
		logic rx_burst;
		rsp.ready <= 1'b0;
		taken = 0;
		rx_burst = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 40 == 0) begin
				rx_burst = ($urandom_range(0, 3) == 0);
			end
			wait_cycles = rx_burst ? 0 : $urandom_range(0, 11);
			if (holds_wanted > holds_done) begin
				holds_done++;
				wait_cycles += HOLD_CYCLES;
			end
			if (wait_cycles > 0) begin
				rsp.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
			taken++;
		end
	end

	// Ends the run when no word moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n === 1'b1 && !(req.valid && req.ready) && !(rsp.valid && rsp.ready)) begin
				quiet++;
			end else begin
				quiet = 0;
			end
		end
		$display("FAILURE");
		$finish;
	end

	// Main stimulus.
	initial begin : stimulus
		arp_in_t      w;
		int           target;
		logic         wanted;
		logic [4:0]   len;
		logic [127:0] text;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PREFIX_WANTED;
		cfg_data <= '0;
		req.valid <= 1'b0;
		req.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset configuration: capture any line.
		send_text("oK", CH_CR);
		send_text("ErRoR", CH_LF);
		send_char(8'hFF);
		send_char(CH_PROMPT);
		send_char(CH_NUL);
		send_read(7'd0);
		send_read(7'd2);
		send_read(7'd127);
		w = '1;
		w.func = FUNC_UNUSED;
		send_word(w);
		send_clear(6'h3F, 1'b0);
		send_char(CH_CR);
		send_clear(6'h00, 1'b1);

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			wanted = 1'b1;
			text = alphabet_prefix();
			case (p)
				0: len = 5'd0;
				1: len = 5'd16;
				2: len = 5'd31;
				3: begin
					len = 5'd8;
					text[31:24] = CH_NUL;
				end
				4: begin
					wanted = 1'b0;
					len = 5'd16;
					text = '1;
				end
				5: begin
					wanted = 1'($urandom_range(0, 1));
					len = 5'($urandom_range(0, 31));
				end
				6: len = 5'($urandom_range(1, 4));
				default: begin
					len = 5'd5;
					text = {$urandom, $urandom, $urandom, $urandom};
				end
			endcase
			configure(wanted, len, text);
			send_clear(6'h3F, 1'b1);
			// Fill the block against a stalled result side.
			if (p == 2 || p == 5) begin
				holds_wanted++;
				fast_words = 60;
			end
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				send_line();
				send_extras();
			end
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
